FILE: hw/rtl/sorted_shift_register_queue_unit_macros.svh
// ----------------------------------------------------------------------------
// sorted shift register queue unit assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ----------------------------------------------------------------------------
`ifndef SORTED_SHIFT_REGISTER_QUEUE_UNIT_MACROS_SVH
`define SORTED_SHIFT_REGISTER_QUEUE_UNIT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SSRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/ssrq_pkg.sv
// ----------------------------------------------------------------------------
// ssrq_pkg
// shared types and constants of the sorted shift register queue unit
// ----------------------------------------------------------------------------
package ssrq_pkg;

  localparam int JOB_W     = 16;
  localparam int POS_W     = 4;
  localparam int DEPTH_DEF = 10;

  // empty marker value after reset
  localparam logic [JOB_W-1:0] MARKER_RST = 16'hFFFF;

  // per-beat operation class, decided by the front
  typedef enum logic [1:0] {
    MODE_HOLD   = 2'd0,
    MODE_INS    = 2'd1,
    MODE_POP    = 2'd2,
    MODE_POPINS = 2'd3
  } mode_t;

  // command handed from front to back
  typedef struct packed {
    logic [JOB_W-1:0] job;
    logic [POS_W-1:0] idx;
    mode_t            mode;
  } cmd_t;

endpackage

FILE: hw/rtl/ssrq_front.sv
// ----------------------------------------------------------------------------
// ssrq_front
// accepts input beats, classifies them and forms the back-end command
// ----------------------------------------------------------------------------
module ssrq_front (
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [ssrq_pkg::JOB_W-1:0]  in_new_job,
  input  logic [ssrq_pkg::POS_W-1:0]  in_insert_position,
  input  logic                        in_pop_req,
  input  logic [ssrq_pkg::JOB_W-1:0]  empty_marker,
  input  logic                        q_full,
  output logic                        q_wr,
  output ssrq_pkg::cmd_t              q_wdata
);

  logic ins;

  assign ins     = (in_new_job != empty_marker);
  assign in_full = q_full;
  assign q_wr    = in_push && !q_full;

  always_comb begin
    q_wdata.job  = in_new_job;
    q_wdata.idx  = in_insert_position;
    q_wdata.mode = ssrq_pkg::MODE_HOLD;
    if (ins && in_pop_req) begin
      q_wdata.mode = ssrq_pkg::MODE_POPINS;
      // job lands one slot nearer the head; positions 0 and 1 both mean head
      if (in_insert_position <= ssrq_pkg::POS_W'(1)) begin
        q_wdata.idx = '0;
      end else begin
        q_wdata.idx = in_insert_position - ssrq_pkg::POS_W'(1);
      end
    end else if (ins) begin
      q_wdata.mode = ssrq_pkg::MODE_INS;
    end else if (in_pop_req) begin
      q_wdata.mode = ssrq_pkg::MODE_POP;
    end
  end

endmodule

FILE: hw/rtl/ssrq_cmd_fifo.sv
// ----------------------------------------------------------------------------
// ssrq_cmd_fifo
// two-entry command queue decoupling front and back
// ----------------------------------------------------------------------------
`include "sorted_shift_register_queue_unit_macros.svh"

module ssrq_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr,
  input  ssrq_pkg::cmd_t wdata,
  output logic           full,
  input  logic           rd,
  output logic           valid,
  output ssrq_pkg::cmd_t rdata
);

  ssrq_pkg::cmd_t mem_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign rdata = mem_r[rd_ptr_r];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  `SSRQ_ASSERT_NOW(a_cnt_range, clk, rst_n, 1'b1, cnt_r != 2'd3, "cmd fifo count out of range")
  `SSRQ_ASSERT_NOW(a_ptr_match, clk, rst_n, (cnt_r == 2'd0) || (cnt_r == 2'd2), wr_ptr_r == rd_ptr_r, "cmd fifo pointers disagree with count")

endmodule

FILE: hw/rtl/ssrq_back.sv
// ----------------------------------------------------------------------------
// ssrq_back
// slot array update, entry count and result register
// ----------------------------------------------------------------------------
`include "sorted_shift_register_queue_unit_macros.svh"

module ssrq_back #(
  parameter int DEPTH = ssrq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ssrq_pkg::JOB_W-1:0]  empty_marker,
  input  logic                        q_valid,
  input  ssrq_pkg::cmd_t              q_rdata,
  output logic                        q_rd,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ssrq_pkg::JOB_W-1:0]  out_head_job,
  output logic [ssrq_pkg::JOB_W-1:0]  out_popped_job,
  output logic                        out_full_res
);

  localparam int JW   = ssrq_pkg::JOB_W;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int IW   = ($clog2(DEPTH) > ssrq_pkg::POS_W) ? $clog2(DEPTH) : ssrq_pkg::POS_W;

  logic [JW-1:0]   slot_r    [DEPTH];
  logic [JW-1:0]   slot_nxt  [DEPTH];
  logic [JW-1:0]   left_w    [DEPTH];
  logic [JW-1:0]   right_w   [DEPTH];
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [IW-1:0]   idx_ext;
  logic            take;
  logic            is_ins, is_pop;

  assign take    = q_valid && (!out_valid_r || out_pop);
  assign q_rd    = take;
  assign idx_ext = IW'(q_rdata.idx);
  assign is_ins  = (q_rdata.mode == ssrq_pkg::MODE_INS) || (q_rdata.mode == ssrq_pkg::MODE_POPINS);
  assign is_pop  = (q_rdata.mode == ssrq_pkg::MODE_POP) || (q_rdata.mode == ssrq_pkg::MODE_POPINS);

  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    if (i == DEPTH - 1) begin : g_left_edge
      assign left_w[i] = empty_marker;
    end else begin : g_left
      assign left_w[i] = slot_r[i+1];
    end
    if (i == 0) begin : g_right_edge
      assign right_w[i] = empty_marker;
    end else begin : g_right
      assign right_w[i] = slot_r[i-1];
    end

    always_comb begin
      case (q_rdata.mode)
        ssrq_pkg::MODE_INS: begin
          if (IW'(i) < idx_ext) begin
            slot_nxt[i] = slot_r[i];
          end else if (IW'(i) == idx_ext) begin
            slot_nxt[i] = q_rdata.job;
          end else begin
            slot_nxt[i] = right_w[i];
          end
        end
        ssrq_pkg::MODE_POPINS: begin
          if (IW'(i) < idx_ext) begin
            slot_nxt[i] = left_w[i];
          end else if (IW'(i) == idx_ext) begin
            slot_nxt[i] = q_rdata.job;
          end else begin
            slot_nxt[i] = slot_r[i];
          end
        end
        ssrq_pkg::MODE_POP: slot_nxt[i] = left_w[i];
        default:            slot_nxt[i] = slot_r[i];
      endcase
    end
  end

  // saturating entry count
  always_comb begin
    cnt_nxt = cnt_r;
    if (is_ins && !is_pop && (cnt_r != CNTW'(DEPTH))) begin
      cnt_nxt = cnt_r + CNTW'(1);
    end else if (is_pop && !is_ins && (cnt_r != '0)) begin
      cnt_nxt = cnt_r - CNTW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (take) begin
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        slot_r[k] <= ssrq_pkg::MARKER_RST;
      end
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        for (int k = 0; k < DEPTH; k++) begin
          slot_r[k] <= slot_nxt[k];
        end
        cnt_r <= cnt_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_head_job   <= slot_nxt[0];
      out_popped_job <= is_pop ? slot_r[0] : empty_marker;
      out_full_res   <= (cnt_nxt == CNTW'(DEPTH));
    end
  end

  assign out_empty = !out_valid_r;

  `SSRQ_ASSERT_NOW(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CNTW'(DEPTH), "entry count above depth")
  `SSRQ_ASSERT_NEXT(a_full_flag, clk, rst_n, take, out_full_res == (cnt_r == CNTW'(DEPTH)), "full flag disagrees with entry count")
  `SSRQ_ASSERT_NEXT(a_hold_state, clk, rst_n, !take, $stable(cnt_r) && $stable(slot_r[0]), "slot state changed without a command")

endmodule

FILE: hw/rtl/sorted_shift_register_queue_unit.sv
// ----------------------------------------------------------------------------
// sorted_shift_register_queue_unit
// register-array sorted job queue with a classifying front, a command queue
// and a slot-update back end
// ----------------------------------------------------------------------------
//
//   channel  | ports                                         | beat when
//   ---------+-----------------------------------------------+------------------
//   input    | in_push, in_full, in_new_job,                 | in_push && !in_full
//            | in_insert_position, in_pop_req                |
//   result   | out_empty, out_pop, out_head_job,             | out_pop && !out_empty
//            | out_popped_job, out_full_res                  |
//   config   | cfg_wr_en, cfg_wr_data (empty marker)         | cfg_wr_en
//
// one beat per cycle sustained while the result side keeps popping; the whole slot array updates together
// an accepted beat is written into the command queue, then loaded into the result
// register when the back takes it (result register empty or being popped)
// rst_n is synchronous: slots return to 0xffff, count to zero, queues empty
// a stalled result side fills the two-entry command queue, then raises in_full
// ----------------------------------------------------------------------------
module sorted_shift_register_queue_unit #(
  parameter int DEPTH = ssrq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_wr_en,
  input  logic [ssrq_pkg::JOB_W-1:0]  cfg_wr_data,
  // input beats
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [ssrq_pkg::JOB_W-1:0]  in_new_job,
  input  logic [ssrq_pkg::POS_W-1:0]  in_insert_position,
  input  logic                        in_pop_req,
  // result beats
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [ssrq_pkg::JOB_W-1:0]  out_head_job,
  output logic [ssrq_pkg::JOB_W-1:0]  out_popped_job,
  output logic                        out_full_res
);

  // empty marker register; the user must write it only while idle, the block does not enforce this
  logic [ssrq_pkg::JOB_W-1:0] marker_r, marker_nxt;

  // front to command queue
  logic           q_wr;
  ssrq_pkg::cmd_t q_wdata;
  logic           q_full;

  // command queue to back
  logic           q_rd;
  logic           q_valid;
  ssrq_pkg::cmd_t q_rdata;

  assign marker_nxt = cfg_wr_en ? cfg_wr_data : marker_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      marker_r <= ssrq_pkg::MARKER_RST;
    end else begin
      marker_r <= marker_nxt;
    end
  end

  // front: accept and classify the beat
  ssrq_front u_front (
    .in_push            (in_push),
    .in_full            (in_full),
    .in_new_job         (in_new_job),
    .in_insert_position (in_insert_position),
    .in_pop_req         (in_pop_req),
    .empty_marker       (marker_r),
    .q_full             (q_full),
    .q_wr               (q_wr),
    .q_wdata            (q_wdata)
  );

  // short queue between front and back
  ssrq_cmd_fifo u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .valid (q_valid),
    .rdata (q_rdata)
  );

  // back: slot update and result register
  ssrq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty_marker   (marker_r),
    .q_valid        (q_valid),
    .q_rdata        (q_rdata),
    .q_rd           (q_rd),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_head_job   (out_head_job),
    .out_popped_job (out_popped_job),
    .out_full_res   (out_full_res)
  );

endmodule
